// ===== rtl/core/fpq_pkg.sv =====
// Shared types, mode codes and constants of the Q24.8 fixed-point ALU.
package fpq_pkg;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned DIV_W     = WORD_W + FRAC_BITS + 2;
  localparam int unsigned CNT_W     = $clog2(DIV_W + 1);
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    MODE_ADD     = 4'd0,
    MODE_SUB     = 4'd1,
    MODE_MUL     = 4'd2,
    MODE_DIV     = 4'd3,
    MODE_GT      = 4'd4,
    MODE_LT      = 4'd5,
    MODE_GE      = 4'd6,
    MODE_LE      = 4'd7,
    MODE_EQ      = 4'd8,
    MODE_NE      = 4'd9,
    MODE_INC     = 4'd10,
    MODE_DEC     = 4'd11,
    MODE_MIN     = 4'd12,
    MODE_MAX     = 4'd13,
    MODE_TOINT   = 4'd14,
    MODE_FROMINT = 4'd15
  } mode_t;

  // Operation class decided by the front end.
  typedef enum logic [2:0] {
    CLS_SIMPLE = 3'b001,
    CLS_MUL    = 3'b010,
    CLS_DIV    = 3'b100
  } op_class_t;

  typedef struct packed {
    op_class_t          cls;
    logic signed [WORD_W-1:0] simple_value;
    logic               compare_true;
    logic               neg;
    logic               divide_by_zero;
    logic [WORD_W-1:0]  mag_a;
    logic [WORD_W-1:0]  mag_b;
  } fpq_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic               compare_true;
    logic               divide_by_zero;
    logic               saturated;
  } fpq_result_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } div_state_t;

  // Round already applied; clamp magnitude q to signed range with sign neg.
  function automatic logic [WORD_W:0] clamp_mag(input logic neg,
                                                input logic [DIV_W-1:0] q);
    logic             nz;
    logic [WORD_W:0]  r;
    nz = neg && (q != '0);
    if (!nz && (q > DIV_W'({1'b0, {(WORD_W-1){1'b1}}}))) begin
      r = {1'b1, 1'b0, {(WORD_W-1){1'b1}}};
    end else if (nz && (q > DIV_W'({1'b1, {(WORD_W-1){1'b0}}}))) begin
      r = {1'b1, 1'b1, {(WORD_W-1){1'b0}}};
    end else if (nz) begin
      r = {1'b0, WORD_W'(~q[WORD_W-1:0] + 1'b1)};
    end else begin
      r = {1'b0, q[WORD_W-1:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/fpq_front.sv =====
// Front end: accept an item, work out simple modes and classify the rest.
module fpq_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              valid,
  output logic                              ready,
  input  logic [3:0]                        mode,
  input  logic signed [fpq_pkg::WORD_W-1:0] operand_a,
  input  logic signed [fpq_pkg::WORD_W-1:0] operand_b,
  output logic                              item_valid,
  input  logic                              item_ready,
  output fpq_pkg::fpq_item_t                item
);

  fpq_pkg::fpq_item_t item_next;
  logic               lt;
  logic               eq;
  logic [fpq_pkg::WORD_W-1:0] ua;

  assign ready = !item_valid || item_ready;
  assign ua    = operand_a;
  assign lt    = operand_a < operand_b;
  assign eq    = operand_a == operand_b;

  always_comb begin
    item_next                = '0;
    item_next.cls            = fpq_pkg::CLS_SIMPLE;
    item_next.neg            = operand_a[fpq_pkg::WORD_W-1] ^ operand_b[fpq_pkg::WORD_W-1];
    item_next.mag_a          = operand_a[fpq_pkg::WORD_W-1] ? -ua : ua;
    item_next.mag_b          = operand_b[fpq_pkg::WORD_W-1] ? -operand_b : operand_b;
    case (fpq_pkg::mode_t'(mode))
      fpq_pkg::MODE_ADD:     item_next.simple_value = operand_a + operand_b;
      fpq_pkg::MODE_SUB:     item_next.simple_value = operand_a - operand_b;
      fpq_pkg::MODE_MUL:     item_next.cls = fpq_pkg::CLS_MUL;
      fpq_pkg::MODE_DIV: begin
        if (operand_b == '0) begin
          item_next.divide_by_zero = 1'b1;
        end else begin
          item_next.cls = fpq_pkg::CLS_DIV;
        end
      end
      fpq_pkg::MODE_GT:      item_next.compare_true = !lt && !eq;
      fpq_pkg::MODE_LT:      item_next.compare_true = lt;
      fpq_pkg::MODE_GE:      item_next.compare_true = !lt;
      fpq_pkg::MODE_LE:      item_next.compare_true = lt || eq;
      fpq_pkg::MODE_EQ:      item_next.compare_true = eq;
      fpq_pkg::MODE_NE:      item_next.compare_true = !eq;
      fpq_pkg::MODE_INC:     item_next.simple_value = operand_a + 1;
      fpq_pkg::MODE_DEC:     item_next.simple_value = operand_a - 1;
      fpq_pkg::MODE_MIN:     item_next.simple_value = lt ? operand_a : operand_b;
      fpq_pkg::MODE_MAX:     item_next.simple_value = (!lt && !eq) ? operand_a : operand_b;
      fpq_pkg::MODE_TOINT:   item_next.simple_value = operand_a >>> fpq_pkg::FRAC_BITS;
      fpq_pkg::MODE_FROMINT: item_next.simple_value = operand_a <<< fpq_pkg::FRAC_BITS;
      default:               item_next.simple_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (ready) begin
      item_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (valid && ready) begin
      item <= item_next;
    end
  end

endmodule

// ===== rtl/core/fpq_queue.sv =====
// Short queue between front and back ends.
module fpq_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fpq_pkg::fpq_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output fpq_pkg::fpq_item_t out_item
);

  localparam int unsigned PTR_W = $clog2(fpq_pkg::QUEUE_DEPTH);

  fpq_pkg::fpq_item_t      slots [fpq_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]        wr_ptr;
  logic [PTR_W-1:0]        rd_ptr;
  logic [PTR_W:0]          fill;
  logic                    push;
  logic                    pop;

  assign in_ready  = fill != (PTR_W+1)'(fpq_pkg::QUEUE_DEPTH);
  assign out_valid = fill != '0;
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

// ===== rtl/core/fpq_back.sv =====
// Back end: finish simple items, registered multiply, serial divide, output register.
module fpq_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  fpq_pkg::fpq_item_t   item,
  output logic                 res_valid,
  input  logic                 res_ready,
  output fpq_pkg::fpq_result_t res
);

  localparam int unsigned PW = 2 * fpq_pkg::WORD_W;
  localparam int unsigned DW = fpq_pkg::DIV_W;

  fpq_pkg::div_state_t  state;
  logic                 out_free;
  logic                 take;
  logic                 is_simple;

  // multiply stage
  logic                 mul_valid;
  logic                 mul_neg;
  logic [PW-1:0]        product;
  logic [PW-1:0]        mul_q;
  logic [fpq_pkg::WORD_W:0] mul_clamp;

  // divider
  logic [DW-1:0]        den;
  logic [DW-1:0]        rem;
  logic [DW-1:0]        quo;
  logic [fpq_pkg::CNT_W-1:0] count;
  logic                 div_neg;
  logic                 div_done;
  logic [DW:0]          rem_shift;
  logic [DW-1:0]        div_q;
  logic [fpq_pkg::WORD_W:0] div_clamp;

  assign out_free  = !res_valid || res_ready;
  assign is_simple = item.cls == fpq_pkg::CLS_SIMPLE;
  // a multiply holds off new items while in its stage; the divider owns the back end while busy
  // and until its result is written
  assign item_ready = (state == fpq_pkg::ST_IDLE) && !mul_valid && !div_done && out_free;
  assign take       = item_valid && item_ready;

  assign mul_q     = (product + PW'(1 << (fpq_pkg::FRAC_BITS - 1))) >> fpq_pkg::FRAC_BITS;
  assign mul_clamp = fpq_pkg::clamp_mag(mul_neg, mul_q[DW-1:0] |
                     DW'({|mul_q[PW-1:DW], {(DW-1){1'b0}}}));
  assign rem_shift = {rem, quo[DW-1]};
  // round half away: q = (2*num + mb) / (2*mb)
  assign div_q     = quo;
  assign div_clamp = fpq_pkg::clamp_mag(div_neg, div_q);

  always_ff @(posedge clk) begin
    if (take && item.cls == fpq_pkg::CLS_MUL) begin
      product <= PW'(item.mag_a) * PW'(item.mag_b);
      mul_neg <= item.neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fpq_pkg::ST_IDLE;
      mul_valid <= 1'b0;
      res_valid <= 1'b0;
      div_done  <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      mul_valid <= take && item.cls == fpq_pkg::CLS_MUL;
      div_done  <= 1'b0;
      case (state)
        fpq_pkg::ST_IDLE: begin
          if (take && item.cls == fpq_pkg::CLS_DIV) state <= fpq_pkg::ST_DIV;
        end
        fpq_pkg::ST_DIV: begin
          if (count == fpq_pkg::CNT_W'(DW - 1)) begin
            state    <= fpq_pkg::ST_IDLE;
            div_done <= 1'b1;
          end
        end
        default: state <= fpq_pkg::ST_IDLE;
      endcase
      if ((take && is_simple) || mul_valid || div_done) res_valid <= 1'b1;
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (take && item.cls == fpq_pkg::CLS_DIV) begin
      den     <= DW'({item.mag_b, 1'b0});
      div_neg <= item.neg;
      rem     <= '0;
      quo     <= DW'({item.mag_a, {(fpq_pkg::FRAC_BITS + 1){1'b0}}}) + DW'(item.mag_b);
      count   <= '0;
    end else if (state == fpq_pkg::ST_DIV) begin
      count <= count + 1'b1;
      if (rem_shift >= {1'b0, den}) begin
        rem <= DW'(rem_shift - {1'b0, den});
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= rem_shift[DW-1:0];
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_simple) begin
      res.value          <= item.simple_value;
      res.compare_true   <= item.compare_true;
      res.divide_by_zero <= item.divide_by_zero;
      res.saturated      <= 1'b0;
    end else if (mul_valid) begin
      res.value          <= mul_clamp[fpq_pkg::WORD_W-1:0];
      res.compare_true   <= 1'b0;
      res.divide_by_zero <= 1'b0;
      res.saturated      <= mul_clamp[fpq_pkg::WORD_W];
    end else if (div_done) begin
      res.value          <= div_clamp[fpq_pkg::WORD_W-1:0];
      res.compare_true   <= 1'b0;
      res.divide_by_zero <= 1'b0;
      res.saturated      <= div_clamp[fpq_pkg::WORD_W];
    end
  end

endmodule

// ===== rtl/core/fixed_point_q24_8_alu.sv =====
// Signed Q24.8 fixed-point ALU, top level.
// Path: front-end item register, queue, back end; multiply passes a product stage, divide a
// serial divider. Simple modes stream one beat per cycle while the output is not stalled;
// the back end takes no new item while a multiply is in its product stage or divider is busy.
// Reset clears the queue pointers, all valid flags and the divider state; data registers are not reset.
module fixed_point_q24_8_alu (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [3:0]                        mode,
  input  logic signed [fpq_pkg::WORD_W-1:0] operand_a,
  input  logic signed [fpq_pkg::WORD_W-1:0] operand_b,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [fpq_pkg::WORD_W-1:0] result_value,
  output logic                              compare_true,
  output logic                              divide_by_zero,
  output logic                              saturated
);

  logic                 f_valid;
  logic                 f_ready;
  fpq_pkg::fpq_item_t   f_item;
  logic                 q_valid;
  logic                 q_ready;
  fpq_pkg::fpq_item_t   q_item;
  fpq_pkg::fpq_result_t res;

  fpq_front u_front (
    .clk, .rst, .valid(in_valid), .ready(in_ready), .mode, .operand_a, .operand_b,
    .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
  );

  fpq_queue u_queue (
    .clk, .rst, .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  fpq_back u_back (
    .clk, .rst, .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
    .res_valid(out_valid), .res_ready(out_ready), .res(res)
  );

  assign result_value   = res.value;
  assign compare_true   = res.compare_true;
  assign divide_by_zero = res.divide_by_zero;
  assign saturated      = res.saturated;

  a_dbz_not_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> !saturated && result_value == '0)
    else $error("divide by zero beat carries a value or saturation");

  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && compare_true |-> result_value == '0 && !saturated)
    else $error("compare beat carries a value");

  a_back_busy: assert property (@(posedge clk) disable iff (rst)
    u_back.state == fpq_pkg::ST_DIV |-> !q_ready)
    else $error("back end took an item while dividing");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the Q24.8 fixed-point ALU: directed and random operations.
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    logic signed [31:0] value;
    logic               cmp;
    logic               dbz;
    logic               sat;
  } alu_res_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [3:0]        mode;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  logic              out_valid;
  logic              out_ready;
  logic signed [31:0] result_value;
  logic              compare_true;
  logic              divide_by_zero;
  logic              saturated;

  alu_res_t  pending_results[$];
  int        mismatches;
  int        hold_off_cycles;
  bit        stall_free;

  fixed_point_q24_8_alu DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_value(result_value), .compare_true(compare_true),
    .divide_by_zero(divide_by_zero), .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Clamp a magnitude with its sign to the signed 32-bit range.
  function automatic alu_res_t clamp_word(input bit neg, input logic [63:0] q);
    alu_res_t r;
    r = '0;
    if (neg && q != 0) begin
      if (q > 64'h8000_0000) begin
        r.value = 32'sh8000_0000;
        r.sat = 1'b1;
      end else begin
        r.value = 32'(-q);
      end
    end else if (q > 64'h7FFF_FFFF) begin
      r.value = 32'sh7FFF_FFFF;
      r.sat = 1'b1;
    end else begin
      r.value = q[31:0];
    end
    return r;
  endfunction

  function automatic alu_res_t alu_predict(input logic [3:0] op,
                                           input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    alu_res_t    r;
    logic [63:0] ma, mb, q;
    bit          neg;
    r = '0;
    ma = a[31] ? 64'(-{32'hFFFF_FFFF, a}) : {32'd0, a};
    mb = b[31] ? 64'(-{32'hFFFF_FFFF, b}) : {32'd0, b};
    ma = ma & 64'h1_FFFF_FFFF;
    mb = mb & 64'h1_FFFF_FFFF;
    neg = a[31] ^ b[31];
    case (fpq_pkg::mode_t'(op))
      fpq_pkg::MODE_ADD: r.value = a + b;
      fpq_pkg::MODE_SUB: r.value = a - b;
      fpq_pkg::MODE_MUL: begin
        q = (ma * mb + 64'd128) >> 8;
        r = clamp_word(neg, q);
      end
      fpq_pkg::MODE_DIV: begin
        if (b == 0) begin
          r.dbz = 1'b1;
        end else begin
          q = (2 * (ma << 8) + mb) / (2 * mb);
          r = clamp_word(neg, q);
        end
      end
      fpq_pkg::MODE_GT: r.cmp = a > b;
      fpq_pkg::MODE_LT: r.cmp = a < b;
      fpq_pkg::MODE_GE: r.cmp = a >= b;
      fpq_pkg::MODE_LE: r.cmp = a <= b;
      fpq_pkg::MODE_EQ: r.cmp = a == b;
      fpq_pkg::MODE_NE: r.cmp = a != b;
      fpq_pkg::MODE_INC: r.value = a + 1;
      fpq_pkg::MODE_DEC: r.value = a - 1;
      fpq_pkg::MODE_MIN: r.value = (a < b) ? a : b;
      fpq_pkg::MODE_MAX: r.value = (a > b) ? a : b;
      fpq_pkg::MODE_TOINT: r.value = a >>> 8;
      default: r.value = a << 8;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'($signed($urandom_range(0, 1024)) - 512);
      3: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  // Offer one beat, hold it until accepted; drop valid only for a gap.
  task automatic send_op(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b,
                         input bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= op;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(alu_predict(op, a, b));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls unless a long hold-off or a stall-free stretch is asked.
  initial begin
    int gap;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_ready <= 1'b0;
      end else if (stall_free) begin
        out_ready <= 1'b1;
      end else begin
        gap = rand_gap();
        out_ready <= (gap == 0);
      end
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    alu_res_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat value=%h", result_value);
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.value !== result_value || exp_r.cmp !== compare_true ||
            exp_r.dbz !== divide_by_zero || exp_r.sat !== saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp v=%h c=%b z=%b s=%b got v=%h c=%b z=%b s=%b",
                     exp_r.value, exp_r.cmp, exp_r.dbz, exp_r.sat,
                     result_value, compare_true, divide_by_zero, saturated);
        end
      end
    end
  end

  task automatic test_directed_corners();
    logic [31:0] edges[6];
    edges = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h100, 32'h80};
    for (int op = 0; op < 16; op++)
      send_op(4'(op), edges[op % 6], edges[(op + 3) % 6]);
    send_op(fpq_pkg::MODE_DIV, 32'h500, 32'h0);
    send_op(fpq_pkg::MODE_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(fpq_pkg::MODE_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_op(fpq_pkg::MODE_MUL, 32'hFFFF_FFFF, 32'h80);
    send_op(fpq_pkg::MODE_MIN, 32'h1234, 32'h1234);
    send_op(fpq_pkg::MODE_MAX, 32'h8000_0000, 32'h8000_0000);
    send_op(fpq_pkg::MODE_DIV, 32'h1, 32'h3);
    send_op(fpq_pkg::MODE_INC, 32'h7FFF_FFFF, 32'h0);
    send_op(fpq_pkg::MODE_DEC, 32'h8000_0000, 32'h0);
  endtask

  task automatic test_random_ops(input int count);
    for (int i = 0; i < count; i++)
      send_op(4'($urandom_range(0, 15)), rand_operand(), rand_operand());
  endtask

  task automatic test_back_pressure();
    hold_off_cycles = 300;
    for (int i = 0; i < 40; i++)
      send_op(($urandom_range(0, 3) == 0) ? fpq_pkg::MODE_MUL : fpq_pkg::MODE_ADD,
              rand_operand(), rand_operand(), 1'b1);
    wait_drained();
  endtask

  task automatic test_streaming();
    stall_free = 1'b1;
    for (int i = 0; i < 100; i++)
      send_op(4'($urandom_range(0, 15)), rand_operand(), rand_operand(), 1'b1);
    wait_drained();
    stall_free = 1'b0;
  endtask

  initial begin
    mismatches = 0;
    hold_off_cycles = 0;
    stall_free = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    mode <= '0;
    operand_a <= '0;
    operand_b <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_corners();
    test_random_ops(600);
    test_back_pressure();
    wait_drained();
    test_streaming();
    test_random_ops(600);
    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/fpq_pkg.sv
rtl/core/fpq_front.sv
rtl/core/fpq_queue.sv
rtl/core/fpq_back.sv
rtl/core/fixed_point_q24_8_alu.sv
dv/tb_top.sv
